/* rtl/duration_stats_accumulator_assert.svh */
// Assertion macros shared by the duration statistics block.
`ifndef DURATION_STATS_ACCUMULATOR_ASSERT_SVH
`define DURATION_STATS_ACCUMULATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DSA_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define DSA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DSA_ASSERT_ALWAYS(label, clk, rst, cond)
`define DSA_ASSERT_SAME(label, clk, rst, ante, cons)
`define DSA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/dsa_pkg.sv */
`timescale 1ns / 1ps
package dsa_pkg;

   localparam int STEP_W = 4;
   localparam int ITER_W = 6;

   typedef logic [STEP_W-1:0] step_type;

   localparam logic [3:0] OP_NONE     = 4'd0;
   localparam logic [3:0] OP_CAPTURE  = 4'd1;
   localparam logic [3:0] OP_LOAD_DUR = 4'd2;
   localparam logic [3:0] OP_DIV_STEP = 4'd3;
   localparam logic [3:0] OP_RECORD   = 4'd4;
   localparam logic [3:0] OP_LOAD_AVG = 4'd5;
   localparam logic [3:0] OP_AVG_DONE = 4'd6;
   localparam logic [3:0] OP_CLEAR    = 4'd7;
   localparam logic [3:0] OP_PUBLISH  = 4'd8;

   localparam logic [2:0] COND_NEVER      = 3'd0;
   localparam logic [2:0] COND_ALWAYS     = 3'd1;
   localparam logic [2:0] COND_NO_REQ     = 3'd2;
   localparam logic [2:0] COND_KIND_CLEAR = 3'd3;
   localparam logic [2:0] COND_CPM_ZERO   = 3'd4;
   localparam logic [2:0] COND_ITER_MORE  = 3'd5;
   localparam logic [2:0] COND_COUNT_ZERO = 3'd6;
   localparam logic [2:0] COND_OUT_BUSY   = 3'd7;

   localparam step_type STEP_IDLE    = 4'd0;
   localparam step_type STEP_KIND    = 4'd1;
   localparam step_type STEP_LOAD    = 4'd2;
   localparam step_type STEP_DUR_DIV = 4'd3;
   localparam step_type STEP_RECORD  = 4'd4;
   localparam step_type STEP_AVG_LD  = 4'd5;
   localparam step_type STEP_AVG_DIV = 4'd6;
   localparam step_type STEP_AVG_END = 4'd7;
   localparam step_type STEP_CLEAR   = 4'd8;
   localparam step_type STEP_PUBLISH = 4'd9;

   localparam logic       KIND_CLEAR = 1'b1;
   localparam logic [5:0] DUR_ITERS  = 6'd31;
   localparam logic [5:0] AVG_ITERS  = 6'd63;

   typedef struct packed {
      logic [3:0] op;
      logic       accept;
      logic [2:0] cond;
      step_type   target;
      logic       last;
   } ctrl_word_type;

   function automatic ctrl_word_type rom_word(input step_type step);
      ctrl_word_type w;
      w = '{op: OP_NONE, accept: 1'b0, cond: COND_NEVER, target: STEP_IDLE, last: 1'b0};
      unique case (step)
         STEP_IDLE: begin
            w = '{OP_CAPTURE, 1'b1, COND_NO_REQ, STEP_IDLE, 1'b0};
         end
         STEP_KIND: begin
            w = '{OP_NONE, 1'b0, COND_KIND_CLEAR, STEP_CLEAR, 1'b0};
         end
         STEP_LOAD: begin
            w = '{OP_LOAD_DUR, 1'b0, COND_CPM_ZERO, STEP_RECORD, 1'b0};
         end
         STEP_DUR_DIV: begin
            w = '{OP_DIV_STEP, 1'b0, COND_ITER_MORE, STEP_DUR_DIV, 1'b0};
         end
         STEP_RECORD: begin
            w = '{OP_RECORD, 1'b0, COND_NEVER, STEP_IDLE, 1'b0};
         end
         STEP_AVG_LD: begin
            w = '{OP_LOAD_AVG, 1'b0, COND_COUNT_ZERO, STEP_PUBLISH, 1'b0};
         end
         STEP_AVG_DIV: begin
            w = '{OP_DIV_STEP, 1'b0, COND_ITER_MORE, STEP_AVG_DIV, 1'b0};
         end
         STEP_AVG_END: begin
            w = '{OP_AVG_DONE, 1'b0, COND_ALWAYS, STEP_PUBLISH, 1'b0};
         end
         STEP_CLEAR: begin
            w = '{OP_CLEAR, 1'b0, COND_NEVER, STEP_IDLE, 1'b0};
         end
         STEP_PUBLISH: begin
            w = '{OP_PUBLISH, 1'b0, COND_OUT_BUSY, STEP_PUBLISH, 1'b1};
         end
         default: begin
            w = '{OP_NONE, 1'b0, COND_ALWAYS, STEP_IDLE, 1'b0};
         end
      endcase
      return w;
   endfunction

endpackage

/* rtl/duration_stats_accumulator.sv */
`timescale 1ns / 1ps
// Latency statistics monitor. Each request on the req_ channel is either a record
// (req_kind 0) carrying start and end stamps of a free-running 32-bit cycle counter,
// or a clear (req_kind 1). Every request yields exactly one response on the rsp_
// channel: the duration in microseconds and the count, minimum, maximum and average
// as they stand after the request. csr_write_data sets cycles per microsecond; write
// it only while no request is in flight. A divisor of zero passes raw cycles through.
// A record's response takes 32 steps for the duration division (skipped with a zero
// divisor) and 64 for the average, both on one shared restoring divider driven by a
// microcode table, one quotient bit per cycle. A clear skips the divider and goes
// straight to its publish step. The sequencer is back in idle as the response is
// loaded, so a new request is taken only once the previous one has been published.
// One request is worked on at a time; req_stall is low only in the idle step.
// The response sits in an output register, so the next request is accepted and
// processed while the previous response waits; when rsp_stall stays high, the
// sequencer holds in its publish step until the register is taken.
// Synchronous reset zeroes all statistics, sets the divisor to 1 and drops rsp_valid.
module duration_stats_accumulator
   import dsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [31:0] req_start_cycles,
   input  logic [31:0] req_end_cycles,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_latency_us,
   output logic [31:0] rsp_sample_count,
   output logic [31:0] rsp_minimum_us,
   output logic [31:0] rsp_maximum_us,
   output logic [31:0] rsp_average_us
);

`include "duration_stats_accumulator_assert.svh"

   ctrl_word_type       cw;
   step_type            step_ff, step_in;
   logic                cond_true;
   logic                out_busy;

   logic [15:0]         cpm_ff;
   logic [31:0]         count_ff, count_in;
   logic [63:0]         total_ff, total_in;
   logic [31:0]         min_ff, min_in;
   logic [31:0]         max_ff, max_in;
   logic [31:0]         avg_ff, avg_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                kind_ff;
   logic [31:0]         elapsed_ff;
   logic [31:0]         dur_ff, dur_in;
   logic [63:0]         dvd_ff, dvd_in;
   logic [31:0]         dvs_ff, dvs_in;
   logic [31:0]         rem_ff, rem_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic [32:0]         rem_shift;
   logic [33:0]         diff;
   logic [31:0]         rec_dur;

   logic [31:0]         out_dur_ff, out_count_ff, out_min_ff, out_max_ff, out_avg_ff;

   assign cw        = rom_word(step_ff);
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign req_stall = !cw.accept;

   always_comb begin
      case (cw.cond)
         COND_NEVER:      cond_true = 1'b0;
         COND_ALWAYS:     cond_true = 1'b1;
         COND_NO_REQ:     cond_true = !req_valid;
         COND_KIND_CLEAR: cond_true = (kind_ff == KIND_CLEAR);
         COND_CPM_ZERO:   cond_true = (cpm_ff == 16'd0);
         COND_ITER_MORE:  cond_true = (iter_ff != '0);
         COND_COUNT_ZERO: cond_true = (count_ff == 32'd0);
         COND_OUT_BUSY:   cond_true = out_busy;
         default:         cond_true = 1'b0;
      endcase
      if (cond_true) begin
         step_in = cw.target;
      end else if (cw.last) begin
         step_in = STEP_IDLE;
      end else begin
         step_in = step_ff + step_type'(1);
      end
   end

   assign rem_shift = {rem_ff, dvd_ff[63]};
   assign diff      = {1'b0, rem_shift} - {2'b00, dvs_ff};
   assign rec_dur   = (cpm_ff == 16'd0) ? elapsed_ff : dvd_ff[31:0];

   always_comb begin
      count_in     = count_ff;
      total_in     = total_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      avg_in       = avg_ff;
      dur_in       = dur_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (cw.op)
         OP_LOAD_DUR: begin
            dvd_in  = {elapsed_ff, 32'd0};
            dvs_in  = {16'd0, cpm_ff};
            rem_in  = 32'd0;
            iter_in = DUR_ITERS;
         end
         OP_DIV_STEP: begin
            iter_in = iter_ff - ITER_W'(1);
            if (!diff[33]) begin
               rem_in = diff[31:0];
               dvd_in = {dvd_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_shift[31:0];
               dvd_in = {dvd_ff[62:0], 1'b0};
            end
         end
         OP_RECORD: begin
            dur_in   = rec_dur;
            count_in = count_ff + 32'd1;
            total_in = total_ff + {32'd0, rec_dur};
            if (rec_dur < min_ff || min_ff == 32'd0) begin
               min_in = rec_dur;
            end
            if (rec_dur > max_ff) begin
               max_in = rec_dur;
            end
         end
         OP_LOAD_AVG: begin
            dvd_in  = total_ff;
            dvs_in  = count_ff;
            rem_in  = 32'd0;
            iter_in = AVG_ITERS;
         end
         OP_AVG_DONE: begin
            avg_in = dvd_ff[31:0];
         end
         OP_CLEAR: begin
            dur_in   = 32'd0;
            count_in = 32'd0;
            total_in = 64'd0;
            min_in   = 32'd0;
            max_in   = 32'd0;
            avg_in   = 32'd0;
         end
         OP_PUBLISH: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         cpm_ff       <= 16'd1;
         count_ff     <= 32'd0;
         total_ff     <= 64'd0;
         min_ff       <= 32'd0;
         max_ff       <= 32'd0;
         avg_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            cpm_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      dur_ff  <= dur_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      iter_ff <= iter_in;
      if (cw.op == OP_CAPTURE && req_valid) begin
         kind_ff    <= req_kind;
         elapsed_ff <= req_end_cycles - req_start_cycles;
      end
      if (cw.op == OP_PUBLISH && !out_busy) begin
         out_dur_ff   <= dur_ff;
         out_count_ff <= count_ff;
         out_min_ff   <= min_ff;
         out_max_ff   <= max_ff;
         out_avg_ff   <= avg_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_latency_us   = out_dur_ff;
   assign rsp_sample_count = out_count_ff;
   assign rsp_minimum_us   = out_min_ff;
   assign rsp_maximum_us   = out_max_ff;
   assign rsp_average_us   = out_avg_ff;

   `DSA_ASSERT_NEXT(a_accept_moves_on, clock, reset, req_valid && !req_stall, step_ff == STEP_KIND)
   `DSA_ASSERT_SAME(a_divisor_nonzero, clock, reset, cw.op == OP_DIV_STEP, dvs_ff != 32'd0)
   `DSA_ASSERT_ALWAYS(a_min_not_above_max, clock, reset, min_ff <= max_ff)

endmodule
